[rtl/hspce_pkg.sv]
// Shared package for the half-sine pulse color envelope.
// Holds register codes, sequencer states, divider status and sine constants.
// No dependencies.
package hspce_pkg;

  localparam int COUNT_BITS_DEF   = 16;
  localparam int SINE_ENTRIES_DEF = 256;

  localparam int PEAK_W    = 17;
  localparam int LEN_W     = 16;
  localparam int COLOR_W   = 32;
  localparam int TEX_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int SINE_W    = 17;
  localparam int PROD_W    = 2 * PEAK_W;

  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_ON     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SILENT_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_PERIOD   = 3'd5;

  localparam logic [PEAK_W-1:0]  PEAK_RST          = 17'd32768;
  localparam logic [LEN_W-1:0]   SIGNAL_LENGTH_RST = 16'd120;
  localparam logic [LEN_W-1:0]   SILENT_LENGTH_RST = 16'd0;
  localparam logic [COLOR_W-1:0] BASE_COLOR_RST    = 32'hFF5C5C5B;
  localparam logic [LEN_W-1:0]   ANIM_PERIOD_RST   = 16'd100;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q16 = 64'd65536;
  localparam logic [63:0] TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_IDX_WAIT,
    ST_SINE,
    ST_AMP,
    ST_TEX,
    ST_TEX_WAIT,
    ST_CH_MUL,
    ST_CH_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[rtl/hspce_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Shared by the sine index and texture offset paths; uses hspce_pkg.
module hspce_div
  import hspce_pkg::*;
#(
  parameter int DW = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DW-1:0]     num,
  input  logic [LEN_W-1:0]  den,
  output logic [DW-1:0]     quo,
  output div_status_t       status
);

  localparam int CW = $clog2(DW + 1);

  logic [LEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic [LEN_W:0]   shifted;
  logic [LEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem, quo[DW-1]};
  assign ge      = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        cnt         <= CW'(DW);
      end else if (status.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (status.busy) begin
      rem <= ge ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
      quo <= {quo[DW-2:0], ge};
    end
  end

endmodule

[rtl/hspce_sine_rom.sv]
// Quarter-wave sine table in Q16, built at elaboration from a Taylor series.
// Registered read; uses hspce_pkg.
module hspce_sine_rom
  import hspce_pkg::*;
#(
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                                       clk,
  input  logic [$clog2(SINE_ENTRIES/2 + 1)-1:0]      addr,
  output logic [SINE_W-1:0]                          data
);

  localparam int HALF      = SINE_ENTRIES / 2;
  localparam int ADDR_W    = $clog2(HALF + 1);
  localparam int ROM_DEPTH = 1 << ADDR_W;

  typedef logic [SINE_W-1:0] rom_t [ROM_DEPTH];

  function automatic logic [SINE_W-1:0] sine_q16(input int i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(i) * PI_Q30) / SINE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 0; k < 5; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if (k % 2 == 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum + 64'd8192) >> 14;
    if (sum > ONE_Q16) begin
      sum = ONE_Q16;
    end
    return sum[SINE_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      r[i] = (i <= HALF) ? sine_q16(i) : '0;
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    data <= ROM[addr];
  end

endmodule

[rtl/half_sine_pulse_color_envelope_top.sv]
// Top level of the half-sine pulse color envelope: config registers, sequencer,
// shared multiplier and counters. Uses hspce_pkg, hspce_div and hspce_sine_rom.
//
// One input transfer per frame reports the envelope-scaled ARGB color and the
// texture offset from the current counters (zero with the effect off), then
// steps both counters when advance is set. With the effect off the sequencer
// goes straight from preparation to done. Outside the pulse, or with a zero
// signal_length, the sine index division is skipped, and with a zero
// anim_period the texture division is skipped. The single restoring divider
// produces one quotient bit per cycle and runs once for the sine index and
// once for the texture offset; the four color channels then share one 17x17
// multiplier in turn. A result waits in the output register until taken; the
// next item is accepted once the sequencer is back at idle, in the cycle
// after the result is loaded, so the block does not take a new item before
// it is through with the last one. Input is not ready during reset.
module half_sine_pulse_color_envelope_top
  import hspce_pkg::*;
#(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [0] advance, [7:1] zero
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,   // [31:0] factor_argb, [47:32] tex_offset
  output logic [0:0]           m_tuser    // [0] active
);

  localparam int SBW    = $clog2(SINE_ENTRIES + 1);
  localparam int DW     = (COUNT_BITS + 16 > 16 + SBW) ? COUNT_BITS + 16 : 16 + SBW;
  localparam int IW     = $clog2(SINE_ENTRIES);
  localparam int ROM_AW = $clog2(SINE_ENTRIES / 2 + 1);
  localparam int PW     = (COUNT_BITS + 1 > LEN_W) ? COUNT_BITS + 1 : LEN_W;
  localparam int LW     = (COUNT_BITS + 1 > LEN_W + 1) ? COUNT_BITS + 1 : LEN_W + 1;
  localparam int AW     = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

  logic                 effect_on;
  logic [PEAK_W-1:0]    peak;
  logic [LEN_W-1:0]     signal_length;
  logic [LEN_W-1:0]     silent_length;
  logic [COLOR_W-1:0]   base_color;
  logic [LEN_W-1:0]     anim_period;

  logic [COUNT_BITS:0]   pulse_count;
  logic [COUNT_BITS-1:0] anim_count;

  state_t state, state_next;

  logic                 adv;
  logic [PEAK_W-1:0]    amp;
  logic [TEX_W-1:0]     tex;
  logic [COLOR_W-1:0]   color;
  logic [1:0]           ch_idx;
  logic [PEAK_W-1:0]    mul_a;
  logic [PEAK_W-1:0]    mul_b;
  logic [PROD_W-1:0]    prod;

  logic                 div_start;
  logic [DW-1:0]        div_num;
  logic [LEN_W-1:0]     div_den;
  logic [DW-1:0]        div_quo;
  div_status_t          div_status;

  logic [ROM_AW-1:0]    rom_addr;
  logic [SINE_W-1:0]    rom_data;

  logic                 need_sine;
  logic                 need_tex;
  logic                 out_free;
  logic [PW-1:0]        pulse_ext;
  logic [DW-1:0]        num_idx;
  logic [DW-1:0]        num_tex;
  logic [IW-1:0]        idx;
  logic [IW:0]          idx_fold;
  logic [IW:0]          se_w;
  logic [COUNT_BITS:0]  pulse_inc;
  logic [LEN_W:0]       pulse_limit;
  logic [COUNT_BITS-1:0] anim_inc;
  logic [7:0]           ch_sat;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      effect_on     <= 1'b0;
      peak          <= PEAK_RST;
      signal_length <= SIGNAL_LENGTH_RST;
      silent_length <= SILENT_LENGTH_RST;
      base_color    <= BASE_COLOR_RST;
      anim_period   <= ANIM_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EFFECT_ON:     effect_on     <= cfg_data[0];
        REG_PEAK:          peak          <= cfg_data[PEAK_W-1:0];
        REG_SIGNAL_LENGTH: signal_length <= cfg_data[LEN_W-1:0];
        REG_SILENT_LENGTH: silent_length <= cfg_data[LEN_W-1:0];
        REG_BASE_COLOR:    base_color    <= cfg_data[COLOR_W-1:0];
        REG_ANIM_PERIOD:   anim_period   <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign pulse_ext = PW'(pulse_count);
  assign need_sine = pulse_ext < PW'(signal_length);
  assign need_tex  = effect_on && (anim_period != '0);
  assign num_idx   = DW'(pulse_ext[LEN_W-1:0]) * DW'(SINE_ENTRIES);
  assign num_tex   = DW'({anim_count, 16'b0});
  assign out_free  = !m_tvalid || m_tready;

  // hold the texture divisor for the whole division
  assign div_num = (state == ST_TEX) ? num_tex : num_idx;
  assign div_den = (state == ST_TEX || state == ST_TEX_WAIT) ? anim_period : signal_length;

  hspce_div #(
    .DW(DW)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quo    (div_quo),
    .status (div_status)
  );

  // fold the index onto the first quarter wave
  assign idx      = div_quo[IW-1:0];
  assign se_w     = (IW + 1)'(SINE_ENTRIES);
  assign idx_fold = ({idx, 1'b0} > se_w) ? (se_w - {1'b0, idx}) : {1'b0, idx};
  assign rom_addr = ROM_AW'(idx_fold);

  hspce_sine_rom #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  // shared multiplier
  always_comb begin
    if (state == ST_SINE) begin
      mul_a = peak;
      mul_b = rom_data;
    end else begin
      mul_a = amp;
      mul_b = PEAK_W'(base_color[{ch_idx, 3'b000} +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign ch_sat = (|prod[PROD_W-1:24]) ? 8'hFF : prod[23:16];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (!effect_on) begin
          state_next = ST_DONE;
        end else if (need_sine) begin
          div_start  = 1'b1;
          state_next = ST_IDX_WAIT;
        end else begin
          state_next = ST_TEX;
        end
      end
      ST_IDX_WAIT: begin
        if (div_status.done) begin
          state_next = ST_SINE;
        end
      end
      ST_SINE: state_next = ST_AMP;
      ST_AMP:  state_next = ST_TEX;
      ST_TEX: begin
        if (need_tex) begin
          div_start  = 1'b1;
          state_next = ST_TEX_WAIT;
        end else begin
          state_next = ST_CH_MUL;
        end
      end
      ST_TEX_WAIT: begin
        if (div_status.done) begin
          state_next = ST_CH_MUL;
        end
      end
      ST_CH_MUL: state_next = ST_CH_ACC;
      ST_CH_ACC: begin
        state_next = (ch_idx == 2'd3) ? ST_DONE : ST_CH_MUL;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        adv <= s_tdata[0];
      end
      ST_PREP: begin
        ch_idx <= 2'd0;
        amp    <= (signal_length == '0) ? peak : '0;
      end
      ST_AMP: begin
        amp <= prod[32:16];
      end
      ST_TEX: begin
        tex <= '0;
      end
      ST_TEX_WAIT: begin
        if (div_status.done) begin
          tex <= div_quo[TEX_W-1:0];
        end
      end
      ST_CH_ACC: begin
        color[{ch_idx, 3'b000} +: 8] <= ch_sat;
        ch_idx <= ch_idx + 2'd1;
      end
      default: begin
      end
    endcase
  end

  // counters
  assign pulse_inc   = pulse_count + 1'b1;
  assign pulse_limit = {1'b0, signal_length} + {1'b0, silent_length};
  assign anim_inc    = anim_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count <= '0;
      anim_count  <= '0;
    end else if (state == ST_DONE && out_free && adv) begin
      pulse_count <= (LW'(pulse_inc) >= LW'(pulse_limit)) ? '0 : pulse_inc;
      anim_count  <= (AW'(anim_inc) >= AW'(anim_period)) ? '0 : anim_inc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tuser <= effect_on;
      m_tdata <= effect_on ? {tex, color} : '0;
    end
  end

endmodule
